/* src/tfp_pkg.sv */
`default_nettype none
package tfp_pkg;

  localparam int LED_W   = 12;
  localparam int PIX_W   = 9;
  localparam int BYTE_W  = 8;
  localparam int SIZE_W  = 11;
  localparam int NUM_W   = 8;
  localparam int IDX_W   = 2;

  localparam int MAX_LED_COUNT     = 2048;
  localparam int MAX_PACKET_PIXELS = 490;
  localparam int MIN_PACKET_PIXELS = 9;
  localparam int MAX_PACKETS       = 255;

  // restoring division, one quotient bit per cycle
  localparam int DIV_STEPS = LED_W;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);

  localparam logic [LED_W-1:0]  LED_COUNT_RST = LED_W'(300);
  localparam logic [PIX_W-1:0]  PIXELS_RST    = PIX_W'(125);
  localparam logic [NUM_W-1:0]  TOTAL_RST     = NUM_W'(3);
  localparam logic [SIZE_W-1:0] TAIL_RST      = SIZE_W'(150);
  localparam logic [SIZE_W-1:0] FULL_RST      = SIZE_W'(375);

  localparam logic [BYTE_W-1:0] HDR_START = 8'h9c;
  localparam logic [BYTE_W-1:0] HDR_TYPE  = 8'hda;
  localparam logic [BYTE_W-1:0] PKT_END   = 8'h36;

  localparam logic [IDX_W-1:0] REG_LED_COUNT = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_PIXELS    = IDX_W'(1);

  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);

  typedef struct packed {
    logic [NUM_W-1:0]  total;
    logic [SIZE_W-1:0] tail;
    logic [SIZE_W-1:0] full;
  } deriv_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              hdr;
    logic [SIZE_W-1:0] size;
    logic [NUM_W-1:0]  num;
    logic [NUM_W-1:0]  total;
    logic              last;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_START,
    ST_TYPE,
    ST_SIZE_HI,
    ST_SIZE_LO,
    ST_NUM,
    ST_TOTAL,
    ST_DATA,
    ST_END
  } step_e;

endpackage
`default_nettype wire

/* src/tpm2net_frame_packetizer_top.sv */
// the first result byte of an input byte passes the command queue and the output register
// throughput: one result byte per cycle while the output is not stalled; an input byte
// yields 7 bytes when it opens a packet, 2 when it closes one and 1 otherwise
// a four-entry command queue sits between the input side and the byte emitter
// reset: 300 leds, 125 pixels per packet, derived values ready at once; after a
// config write the 12-step divider runs and the first byte of a frame waits for it
`default_nettype none
module tpm2net_frame_packetizer_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [tfp_pkg::BYTE_W-1:0]  led_byte_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [tfp_pkg::BYTE_W-1:0]       out_byte_o,
  output logic                             packet_end_o,
  output logic                             run_last_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [tfp_pkg::IDX_W-1:0]   cfg_index_i,
  input  wire logic [tfp_pkg::LED_W-1:0]   cfg_data_i
);

  logic            deriv_busy;
  tfp_pkg::deriv_t deriv;
  logic            q_full;
  logic            q_push;
  tfp_pkg::cmd_t   q_cmd;
  logic            q_pop;
  logic            q_valid;
  tfp_pkg::cmd_t   q_head;

  assign cfg_ready_o = 1'b1;

  tfp_derive u_derive (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .busy_o      (deriv_busy),
    .deriv_o     (deriv)
  );

  tfp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .led_byte_i (led_byte_i),
    .busy_i     (deriv_busy),
    .deriv_i    (deriv),
    .full_i     (q_full),
    .push_o     (q_push),
    .cmd_o      (q_cmd)
  );

  tfp_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  tfp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_i       (q_head),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .packet_end_o (packet_end_o),
    .run_last_o   (run_last_o)
  );

  // the end byte always closes the transfer of its input byte
  a_end_closes_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && packet_end_o |-> run_last_o && out_byte_o == tfp_pkg::PKT_END)
    else $error("end byte not last of its run");

  // a config write always restarts the derivation
  a_cfg_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> deriv_busy)
    else $error("config write did not start derivation");

endmodule
`default_nettype wire

/* src/tfp_derive.sv */
`default_nettype none
module tfp_derive (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_valid_i,
  input  wire logic [tfp_pkg::IDX_W-1:0]  cfg_index_i,
  input  wire logic [tfp_pkg::LED_W-1:0]  cfg_data_i,
  output logic                            busy_o,
  output tfp_pkg::deriv_t                 deriv_o
);

  logic [tfp_pkg::LED_W-1:0]  led_q;
  logic [tfp_pkg::PIX_W-1:0]  pix_q;
  logic                       restart_q;
  logic                       run_q;
  logic [tfp_pkg::CNT_W-1:0]  cnt_q;
  logic [tfp_pkg::LED_W-1:0]  dvd_q;
  logic [tfp_pkg::PIX_W-1:0]  div_q;
  logic [tfp_pkg::PIX_W-1:0]  rem_q;
  logic [tfp_pkg::NUM_W-1:0]  quo_q;
  tfp_pkg::deriv_t            deriv_q;

  logic [tfp_pkg::PIX_W-1:0]   pix_c;
  logic [tfp_pkg::LED_W-1:0]   led_a;
  logic [tfp_pkg::LED_W-1:0]   led_c;
  logic [tfp_pkg::PIX_W+7:0]   cap;
  logic [tfp_pkg::PIX_W:0]     trial;
  logic                        ge;
  logic [tfp_pkg::PIX_W-1:0]   rem_n;
  logic [tfp_pkg::NUM_W-1:0]   quo_n;
  tfp_pkg::deriv_t             res;

  always_comb begin
    if (pix_q < tfp_pkg::PIX_W'(tfp_pkg::MIN_PACKET_PIXELS)) begin
      pix_c = tfp_pkg::PIX_W'(tfp_pkg::MIN_PACKET_PIXELS);
    end else if (pix_q > tfp_pkg::PIX_W'(tfp_pkg::MAX_PACKET_PIXELS)) begin
      pix_c = tfp_pkg::PIX_W'(tfp_pkg::MAX_PACKET_PIXELS);
    end else begin
      pix_c = pix_q;
    end
    if (led_q == '0) begin
      led_a = tfp_pkg::LED_W'(1);
    end else if (led_q > tfp_pkg::LED_W'(tfp_pkg::MAX_LED_COUNT)) begin
      led_a = tfp_pkg::LED_W'(tfp_pkg::MAX_LED_COUNT);
    end else begin
      led_a = led_q;
    end
    // keep the packet count within one byte
    cap = (tfp_pkg::PIX_W+8)'(tfp_pkg::MAX_PACKETS) * (tfp_pkg::PIX_W+8)'(pix_c);
    if ((tfp_pkg::PIX_W+8)'(led_a) > cap) begin
      led_c = tfp_pkg::LED_W'(cap);
    end else begin
      led_c = led_a;
    end
  end

  always_comb begin
    trial = {rem_q, dvd_q[tfp_pkg::LED_W-1]};
    ge    = trial >= {1'b0, div_q};
    rem_n = ge ? tfp_pkg::PIX_W'(trial - {1'b0, div_q}) : tfp_pkg::PIX_W'(trial);
    quo_n = {quo_q[tfp_pkg::NUM_W-2:0], ge};
    res.tail  = tfp_pkg::SIZE_W'(rem_n) + tfp_pkg::SIZE_W'({rem_n, 1'b0});
    res.total = quo_n + tfp_pkg::NUM_W'(rem_n != '0);
    res.full  = tfp_pkg::SIZE_W'(div_q) + tfp_pkg::SIZE_W'({div_q, 1'b0});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_q       <= tfp_pkg::LED_COUNT_RST;
      pix_q       <= tfp_pkg::PIXELS_RST;
      restart_q   <= 1'b0;
      run_q       <= 1'b0;
      cnt_q       <= '0;
      deriv_q.total <= tfp_pkg::TOTAL_RST;
      deriv_q.tail  <= tfp_pkg::TAIL_RST;
      deriv_q.full  <= tfp_pkg::FULL_RST;
    end else begin
      if (cfg_valid_i && cfg_index_i == tfp_pkg::REG_LED_COUNT) begin
        led_q <= cfg_data_i;
      end
      if (cfg_valid_i && cfg_index_i == tfp_pkg::REG_PIXELS) begin
        pix_q <= cfg_data_i[tfp_pkg::PIX_W-1:0];
      end
      if (cfg_valid_i) begin
        restart_q <= 1'b1;
      end else if (restart_q) begin
        restart_q <= 1'b0;
        run_q     <= 1'b1;
        cnt_q     <= tfp_pkg::CNT_W'(tfp_pkg::DIV_STEPS);
      end else if (run_q) begin
        cnt_q <= cnt_q - tfp_pkg::CNT_W'(1);
        if (cnt_q == tfp_pkg::CNT_W'(1)) begin
          run_q   <= 1'b0;
          deriv_q <= res;
        end
      end
    end
  end

  // datapath of the divider
  always_ff @(posedge clk_i) begin
    if (restart_q) begin
      dvd_q <= led_c;
      div_q <= pix_c;
      rem_q <= '0;
      quo_q <= '0;
    end else if (run_q) begin
      dvd_q <= {dvd_q[tfp_pkg::LED_W-2:0], 1'b0};
      rem_q <= rem_n;
      quo_q <= quo_n;
    end
  end

  assign busy_o  = restart_q || run_q;
  assign deriv_o = deriv_q;

endmodule
`default_nettype wire

/* src/tfp_front.sv */
`default_nettype none
module tfp_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [tfp_pkg::BYTE_W-1:0]  led_byte_i,
  input  wire logic                        busy_i,
  input  wire tfp_pkg::deriv_t             deriv_i,
  input  wire logic                        full_i,
  output logic                             push_o,
  output tfp_pkg::cmd_t                    cmd_o
);

  logic [tfp_pkg::SIZE_W-1:0] bip_q, bip_d;
  logic [tfp_pkg::NUM_W-1:0]  num_q, num_d;
  tfp_pkg::deriv_t            act_q;

  logic                       frame_start;
  tfp_pkg::deriv_t            cur;
  logic                       accept;
  logic [tfp_pkg::SIZE_W-1:0] size;
  logic [tfp_pkg::SIZE_W-1:0] bip_inc;
  logic                       pkt_done;

  always_comb begin
    frame_start = (bip_q == '0) && (num_q == tfp_pkg::NUM_W'(1));
    cur         = frame_start ? deriv_i : act_q;
    in_stall_o  = full_i || (frame_start && busy_i);
    accept      = in_valid_i && !in_stall_o;
    size        = (num_q >= cur.total && cur.tail != '0) ? cur.tail : cur.full;
    bip_inc     = bip_q + tfp_pkg::SIZE_W'(1);
    pkt_done    = bip_inc >= size;

    cmd_o.data  = led_byte_i;
    cmd_o.hdr   = bip_q == '0;
    cmd_o.size  = size;
    cmd_o.num   = num_q;
    cmd_o.total = cur.total;
    cmd_o.last  = pkt_done;
    push_o      = accept;

    bip_d = bip_q;
    num_d = num_q;
    if (accept) begin
      if (pkt_done) begin
        bip_d = '0;
        num_d = (num_q >= cur.total) ? tfp_pkg::NUM_W'(1) : num_q + tfp_pkg::NUM_W'(1);
      end else begin
        bip_d = bip_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bip_q <= '0;
      num_q <= tfp_pkg::NUM_W'(1);
    end else begin
      bip_q <= bip_d;
      num_q <= num_d;
    end
  end

  // derived values are frozen for the whole frame
  always_ff @(posedge clk_i) begin
    if (accept && frame_start) begin
      act_q <= deriv_i;
    end
  end

endmodule
`default_nettype wire

/* src/tfp_cmd_fifo.sv */
`default_nettype none
module tfp_cmd_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire tfp_pkg::cmd_t  cmd_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output tfp_pkg::cmd_t       head_o
);

  tfp_pkg::cmd_t                mem_q [tfp_pkg::CMD_DEPTH];
  logic [tfp_pkg::CMD_PTR_W-1:0] wr_q;
  logic [tfp_pkg::CMD_PTR_W-1:0] rd_q;
  logic [tfp_pkg::CMD_PTR_W:0]   cnt_q;
  logic                          do_push;
  logic                          do_pop;

  assign full_o  = cnt_q == (tfp_pkg::CMD_PTR_W+1)'(tfp_pkg::CMD_DEPTH);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + tfp_pkg::CMD_PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + tfp_pkg::CMD_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + (tfp_pkg::CMD_PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - (tfp_pkg::CMD_PTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule
`default_nettype wire

/* src/tfp_back.sv */
`default_nettype none
module tfp_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        head_valid_i,
  input  wire tfp_pkg::cmd_t               head_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [tfp_pkg::BYTE_W-1:0]       out_byte_o,
  output logic                             packet_end_o,
  output logic                             run_last_o
);

  logic                        started_q, started_d;
  tfp_pkg::step_e              step_q, step_d;
  logic                        out_valid_q, out_valid_d;
  logic [tfp_pkg::BYTE_W-1:0]  out_byte_q;
  logic                        out_end_q;
  logic                        out_last_q;

  tfp_pkg::step_e              cur;
  tfp_pkg::step_e              nxt;
  logic [tfp_pkg::BYTE_W-1:0]  byte_c;
  logic                        end_c;
  logic                        last_c;
  logic                        load;

  always_comb begin
    if (started_q) begin
      cur = step_q;
    end else begin
      cur = head_i.hdr ? tfp_pkg::ST_START : tfp_pkg::ST_DATA;
    end
  end

  // next step
  always_comb begin
    unique case (cur)
      tfp_pkg::ST_START:   nxt = tfp_pkg::ST_TYPE;
      tfp_pkg::ST_TYPE:    nxt = tfp_pkg::ST_SIZE_HI;
      tfp_pkg::ST_SIZE_HI: nxt = tfp_pkg::ST_SIZE_LO;
      tfp_pkg::ST_SIZE_LO: nxt = tfp_pkg::ST_NUM;
      tfp_pkg::ST_NUM:     nxt = tfp_pkg::ST_TOTAL;
      tfp_pkg::ST_TOTAL:   nxt = tfp_pkg::ST_DATA;
      tfp_pkg::ST_DATA:    nxt = tfp_pkg::ST_END;
      tfp_pkg::ST_END:     nxt = tfp_pkg::ST_START;
      default:             nxt = tfp_pkg::ST_START;
    endcase
  end

  // byte for the current step
  always_comb begin
    end_c  = 1'b0;
    last_c = 1'b0;
    unique case (cur)
      tfp_pkg::ST_START:   byte_c = tfp_pkg::HDR_START;
      tfp_pkg::ST_TYPE:    byte_c = tfp_pkg::HDR_TYPE;
      tfp_pkg::ST_SIZE_HI: byte_c = tfp_pkg::BYTE_W'(head_i.size >> 8);
      tfp_pkg::ST_SIZE_LO: byte_c = head_i.size[tfp_pkg::BYTE_W-1:0];
      tfp_pkg::ST_NUM:     byte_c = head_i.num;
      tfp_pkg::ST_TOTAL:   byte_c = head_i.total;
      tfp_pkg::ST_DATA: begin
        byte_c = head_i.data;
        last_c = !head_i.last;
      end
      tfp_pkg::ST_END: begin
        byte_c = tfp_pkg::PKT_END;
        end_c  = 1'b1;
        last_c = 1'b1;
      end
      default:             byte_c = tfp_pkg::HDR_START;
    endcase
  end

  always_comb begin
    load        = head_valid_i && (!out_valid_q || !out_stall_i);
    pop_o       = load && last_c;
    started_d   = started_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (load) begin
      started_d   = !last_c;
      step_d      = nxt;
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      step_q      <= tfp_pkg::ST_START;
      out_valid_q <= 1'b0;
    end else begin
      started_q   <= started_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= byte_c;
      out_end_q  <= end_c;
      out_last_q <= last_c;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign packet_end_o = out_end_q;
  assign run_last_o   = out_last_q;

endmodule
`default_nettype wire
